// ===== rtl/stbs_pkg.sv =====
// Package: shared widths, command codes and controller state type for the table search block.
`default_nettype none

package stbs_pkg;

   localparam int unsigned ITEM_VALUE_WIDTH = 32;
   localparam int unsigned POSITION_WIDTH   = 8;
   localparam int unsigned COUNT_WIDTH      = 9;

   typedef enum logic [0:0] {
      CMD_WRITE  = 1'b0,
      CMD_SEARCH = 1'b1
   } command_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_PROBE = 4'b0010,
      ST_CMP   = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/stbs_if.sv =====
// Interfaces: request and response channels of the table search block.
`default_nettype none

interface stbs_req_if;
   import stbs_pkg::*;

   logic                              valid;
   logic                              ready;
   logic [0:0]                        command;
   logic [POSITION_WIDTH-1:0]         entry_position;
   logic signed [ITEM_VALUE_WIDTH-1:0] item_value;

   modport source (output valid, output command, output entry_position, output item_value,
                   input ready);
   modport sink   (input valid, input command, input entry_position, input item_value,
                   output ready);
endinterface

interface stbs_rsp_if;
   import stbs_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      found;
   logic [POSITION_WIDTH-1:0] match_position;

   modport source (output valid, output found, output match_position, input ready);
   modport sink   (input valid, input found, input match_position, output ready);
endinterface

`default_nettype wire

// ===== rtl/sorted_table_binary_search.sv =====
// Top level: sorted table with write and binary search commands over one synchronous RAM.
// Write transfer: stored at the accepting edge, no response; writes go back to back.
// Search: P probes, each a RAM read (ST_PROBE) then a compare (ST_CMP), P <= floor(log2(n))+1
//   for n entries; a miss ends in one more ST_PROBE on an empty window, then ST_DONE.
// One item in flight: ST_DONE loads the response once the output is free and returns to ST_IDLE,
//   the only state that takes requests. Sync reset clears control, count, output valid.
`default_nettype none

module sorted_table_binary_search #(
   parameter int unsigned TABLE_DEPTH = 256,
   parameter int unsigned VALUE_WIDTH = 32
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_write_enable,
   input  wire [stbs_pkg::COUNT_WIDTH-1:0]  csr_write_data,
   stbs_req_if.sink                         req_ch,
   stbs_rsp_if.source                       rsp_ch
);
   import stbs_pkg::*;

   // AW indexes the table, CW holds 0..TABLE_DEPTH (window bounds), NW compares the count.
   localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned NW = (CW > COUNT_WIDTH) ? CW : COUNT_WIDTH;

   // Config register
   logic [COUNT_WIDTH-1:0] entry_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else if (csr_write_enable) begin
         entry_count_ff <= csr_write_data;
      end
   end

   // Saturate the count at the table depth
   logic [NW-1:0] count_wide;
   logic [CW-1:0] count_sat;

   always_comb begin
      count_wide = NW'(entry_count_ff);
      if (count_wide > NW'(TABLE_DEPTH)) begin
         count_sat = CW'(TABLE_DEPTH);
      end else begin
         count_sat = CW'(count_wide);
      end
   end

   // Controller state
   state_type              state_ff, state_in;
   logic [CW-1:0]          low_ff, low_in;     // first live entry
   logic [CW-1:0]          end_ff, end_in;     // one past last live entry
   logic [CW-1:0]          mid_ff, mid_in;
   logic [VALUE_WIDTH-1:0] target_ff, target_in;
   logic                   found_ff, found_in;

   // Output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_found_ff, rsp_found_in;
   logic [POSITION_WIDTH-1:0] rsp_pos_ff, rsp_pos_in;

   // Table RAM
   logic [VALUE_WIDTH-1:0] table_mem [TABLE_DEPTH];
   logic [VALUE_WIDTH-1:0] rd_data_ff;
   logic                   mem_wr_en;
   logic [AW-1:0]          mem_wr_addr;
   logic [VALUE_WIDTH-1:0] mem_wr_data;
   logic                   mem_rd_en;

   logic           req_xfer;
   logic           rsp_free;
   logic [CW-1:0]  span;
   logic           window_empty;
   logic           probe_eq;
   logic           probe_lt;  // entry below target: move right

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   // Values count only in their low VALUE_WIDTH bits, zero-extended when wider.
   assign mem_wr_en   = req_xfer && (req_ch.command == CMD_WRITE) &&
                        (32'(req_ch.entry_position) < 32'(TABLE_DEPTH));
   assign mem_wr_addr = AW'(req_ch.entry_position);
   assign mem_wr_data = VALUE_WIDTH'($unsigned(req_ch.item_value));

   assign window_empty = !(low_ff < end_ff);
   assign span         = end_ff - low_ff - CW'(1);
   assign mem_rd_en    = (state_ff == ST_PROBE) && !window_empty;

   assign probe_eq = (rd_data_ff == target_ff);
   assign probe_lt = ($signed(rd_data_ff) < $signed(target_ff));

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         table_mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_data_ff <= table_mem[mid_in[AW-1:0]];
      end
   end

   always_comb begin
      state_in     = state_ff;
      low_in       = low_ff;
      end_in       = end_ff;
      mid_in       = mid_ff;
      target_in    = target_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_found_in = rsp_found_ff;
      rsp_pos_in   = rsp_pos_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && (req_ch.command == CMD_SEARCH)) begin
               low_in    = '0;
               end_in    = count_sat;
               target_in = VALUE_WIDTH'($unsigned(req_ch.item_value));
               found_in  = 1'b0;
               state_in  = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (window_empty) begin
               found_in = 1'b0;
               state_in = ST_DONE;
            end else begin
               mid_in   = low_ff + (span >> 1);
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (probe_eq) begin
               found_in = 1'b1;
               state_in = ST_DONE;
            end else if (probe_lt) begin
               low_in   = mid_ff + CW'(1);
               state_in = ST_PROBE;
            end else begin
               end_in   = mid_ff;
               state_in = ST_PROBE;
            end
         end
         ST_DONE: begin
            // wait here while an older response is still unclaimed
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_pos_in   = found_ff ? POSITION_WIDTH'(mid_ff) : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      low_ff       <= low_in;
      end_ff       <= end_in;
      mid_ff       <= mid_in;
      target_ff    <= target_in;
      found_ff     <= found_in;
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.found          = rsp_found_ff;
   assign rsp_ch.match_position = rsp_pos_ff;

endmodule

`default_nettype wire
